// File: hdl/pidstep_pkg.sv
// pidstep_pkg: widths, register indexes and fixed constants of the pid step core
// no dependencies; imported by the interfaces and every module of the core
`default_nettype none

package pidstep_pkg;

    // field widths
    localparam int ERR_W      = 32;
    localparam int DT_W       = 16;
    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 31;
    localparam int INTEG_W    = 48;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // digit serial multiplier: op_a times op_b, op_b consumed one digit a cycle
    localparam int MAC_A_W     = 48;
    localparam int MAC_B_W     = 24;
    localparam int MAC_DIGIT_W = 4;
    localparam int MAC_DIGITS  = MAC_B_W / MAC_DIGIT_W;
    localparam int MAC_CNT_W   = $clog2(MAC_DIGITS);
    localparam int PROD_W      = MAC_A_W + MAC_B_W;

    // digit serial divider: unsigned dividend over a time step
    localparam int DIV_W       = 56;
    localparam int DIV_DIGIT_W = 4;
    localparam int DIV_STEPS   = DIV_W / DIV_DIGIT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // exact sum of the three terms
    localparam int SUM_W = 58;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT  = 8'd3;

    // integrator saturation bounds
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic        [DT_W-1:0]   dt_t;
    typedef logic signed [GAIN_W-1:0] gain_t;
    typedef logic        [LIMIT_W-1:0] limit_t;

endpackage

`default_nettype wire

// File: hdl/pidstep_ifs.sv
// pidstep channel interfaces: sample request, result request and register writes
// depends on pidstep_pkg for field widths and types
`default_nettype none

interface pidstep_in_if import pidstep_pkg::*; ();
    logic valid;
    logic ready;
    err_t error_sample;
    dt_t  time_step;

    modport source (output valid, error_sample, time_step, input ready);
    modport sink   (input valid, error_sample, time_step, output ready);
endinterface

interface pidstep_out_if import pidstep_pkg::*; ();
    logic       valid;
    logic       ready;
    err_t       drive;
    logic       clamped;

    modport source (output valid, drive, clamped, input ready);
    modport sink   (input valid, drive, clamped, output ready);
endinterface

interface pidstep_cfg_if import pidstep_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/pidstep_mac.sv
// pidstep_mac: signed multiplier that consumes op_b one 4-bit digit per cycle
// depends on pidstep_pkg for operand widths and digit count
`default_nettype none

module pidstep_mac import pidstep_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [MAC_A_W-1:0] op_a,
    input  logic signed [MAC_B_W-1:0] op_b,
    output logic                      done,
    output logic signed [PROD_W-1:0]  product
);

    localparam int HI_W  = MAC_A_W + MAC_DIGIT_W;
    localparam int ACC_W = HI_W + 1;

    logic                      busy_reg;
    logic                      done_reg;
    logic [MAC_CNT_W-1:0]      cnt_reg;
    logic signed [MAC_A_W-1:0] a_reg;
    logic signed [HI_W-1:0]    hi_reg;
    logic [MAC_B_W-1:0]        lo_reg;

    logic                      last;
    logic signed [MAC_DIGIT_W:0] digit;
    logic signed [ACC_W-1:0]   pp;
    logic signed [ACC_W-1:0]   acc;
    logic signed [HI_W-1:0]    hi_next;
    logic [MAC_B_W-1:0]        lo_next;

    always_comb
    begin
        last = (cnt_reg == MAC_CNT_W'(MAC_DIGITS - 1));
        // top digit carries the sign of op_b
        if (last)
        begin
            digit = $signed({lo_reg[MAC_DIGIT_W-1], lo_reg[MAC_DIGIT_W-1:0]});
        end
        else
        begin
            digit = $signed({1'b0, lo_reg[MAC_DIGIT_W-1:0]});
        end
        pp      = a_reg * digit;
        acc     = ACC_W'(hi_reg) + pp;
        hi_next = HI_W'(acc >>> MAC_DIGIT_W);
        lo_next = {acc[MAC_DIGIT_W-1:0], lo_reg[MAC_B_W-1:MAC_DIGIT_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= op_a;
            hi_reg <= '0;
            lo_reg <= op_b;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done    = done_reg;
    assign product = $signed({hi_reg[MAC_A_W-1:0], lo_reg});

endmodule

`default_nettype wire

// File: hdl/pidstep_div.sv
// pidstep_div: restoring divider, four quotient bits per cycle
// depends on pidstep_pkg for dividend width and step count
`default_nettype none

module pidstep_div import pidstep_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DT_W-1:0]  divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DT_W-1:0]      rem_reg;
    logic [DT_W-1:0]      dvs_reg;

    logic                 last;
    logic [DIV_W-1:0]     quo_next;
    logic [DT_W-1:0]      rem_next;
    logic [DT_W:0]        trial;

    // dividend bits leave at the top of quo_reg while quotient bits enter below
    always_comb
    begin
        last     = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_DIGIT_W; i++)
        begin
            trial    = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial       = trial - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[DT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: hdl/pid_controller_step_core.sv
// pid_controller_step_core: fixed point pid step with a sequencer over serial units
// depends on pidstep_pkg, pidstep_ifs, pidstep_mac and pidstep_div
//
// usage:
//   cfg     register write request (index, data); always ready, one write per cycle
//           0 proportional gain, 1 integral gain, 2 derivative gain, 3 output limit
//   sample  error sample and time step request; taken only while the core is idle
//   result  drive value and clamp flag request, held in an output register
// sequencing:
//   a zero gain skips its products; each product is 6 passes of the 4-bit digit
//   multiplier plus a start and an accumulate step, and a nonzero derivative with
//   a nonzero time step adds 14 divider digit steps
//   one sample in flight at a time; the next sample is taken once the previous
//   result has moved into the output register, even if result is not yet taken
// reset:
//   gains clear to zero, limit to full scale, integrator and previous error to zero
// stall:
//   a waiting result holds valid and payload; a finished sample waits in the final
//   state until the output register frees up, so nothing is dropped
`default_nettype none

module pid_controller_step_core import pidstep_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    pidstep_cfg_if.sink   cfg,
    pidstep_in_if.sink    sample,
    pidstep_out_if.source result
);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_P_GO     = 4'd1;
    localparam logic [3:0] S_P_WAIT   = 4'd2;
    localparam logic [3:0] S_I_GO     = 4'd3;
    localparam logic [3:0] S_INC_WAIT = 4'd4;
    localparam logic [3:0] S_IACC_GO  = 4'd5;
    localparam logic [3:0] S_I_WAIT   = 4'd6;
    localparam logic [3:0] S_D_GO     = 4'd7;
    localparam logic [3:0] S_D_WAIT   = 4'd8;
    localparam logic [3:0] S_DIV_WAIT = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    // configuration registers
    gain_t                 kp_reg;
    gain_t                 ki_reg;
    gain_t                 kd_reg;
    limit_t                limit_reg;
    logic signed [ERR_W-1:0] lim_neg_reg;

    // sequencer and working state
    logic [3:0]              state_reg, state_next;
    err_t                    e_reg, e_next;
    dt_t                     dt_reg, dt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    neg_reg, neg_next;
    logic signed [INTEG_W-1:0] integral_reg, integral_next;
    err_t                    prev_reg, prev_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    err_t                    drive_reg, drive_next;
    logic                    clamped_reg, clamped_next;

    // serial units
    logic                      mac_start;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic                      mac_done;
    logic signed [PROD_W-1:0]  mac_prod;
    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quot;

    // datapath helpers
    logic signed [SUM_W-1:0]   rnd_term;
    logic signed [ERR_W:0]     diff;
    logic signed [INTEG_W:0]   acc_w;
    logic signed [INTEG_W-1:0] integ_sat;
    logic [DIV_W:0]            num_mag;
    logic [SUM_W-1:0]          q_ext;
    logic [SUM_W-1:0]          d_term;
    logic signed [SUM_W-1:0]   lim_pos;
    logic                      over;
    logic                      under;
    logic                      out_free;

    pidstep_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mac_start),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .done    (mac_done),
        .product (mac_prod)
    );

    pidstep_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // register writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            limit_reg   <= {LIMIT_W{1'b1}};
            lim_neg_reg <= -$signed({1'b0, {LIMIT_W{1'b1}}});
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GAIN_PROP:
                begin
                    kp_reg <= $signed(cfg.data[GAIN_W-1:0]);
                end
                REG_GAIN_INTEGRAL:
                begin
                    ki_reg <= $signed(cfg.data[GAIN_W-1:0]);
                end
                REG_GAIN_DERIV:
                begin
                    kd_reg <= $signed(cfg.data[GAIN_W-1:0]);
                end
                REG_OUTPUT_LIMIT:
                begin
                    limit_reg   <= cfg.data[LIMIT_W-1:0];
                    // negated limit kept ready for the final clamp
                    lim_neg_reg <= -$signed({1'b0, cfg.data[LIMIT_W-1:0]});
                end
                default:
                begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    always_comb
    begin
        // round to nearest q16.16: floor of product / 2^16 plus the half bit
        rnd_term = SUM_W'($signed(mac_prod[PROD_W-1:16])) + SUM_W'(mac_prod[15]);

        diff = (ERR_W+1)'(e_reg) - (ERR_W+1)'(prev_reg);

        // integrator update, saturating at 48 bits
        acc_w = (INTEG_W+1)'(integral_reg)
              + (INTEG_W+1)'($signed(mac_prod[INTEG_W:16]))
              + (INTEG_W+1)'(mac_prod[15]);
        if (acc_w[INTEG_W] != acc_w[INTEG_W-1])
        begin
            integ_sat = acc_w[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end
        else
        begin
            integ_sat = acc_w[INTEG_W-1:0];
        end

        // magnitude of the derivative numerator, which fits 56 bits
        if (mac_prod[PROD_W-1])
        begin
            num_mag = (DIV_W+1)'(0) - mac_prod[DIV_W:0];
        end
        else
        begin
            num_mag = mac_prod[DIV_W:0];
        end

        // signed quotient added as ones complement plus carry
        q_ext  = SUM_W'(div_quot);
        d_term = neg_reg ? ~q_ext : q_ext;

        // final clamp; the limit never exceeds 32-bit full scale
        lim_pos = $signed(SUM_W'(limit_reg));
        over    = (sum_reg > lim_pos);
        under   = (sum_reg < SUM_W'(lim_neg_reg));
    end

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next    = state_reg;
        e_next        = e_reg;
        dt_next       = dt_reg;
        sum_next      = sum_reg;
        neg_next      = neg_reg;
        integral_next = integral_reg;
        prev_next     = prev_reg;
        mac_start     = 1'b0;
        mac_a         = MAC_A_W'(e_reg);
        mac_b         = kp_reg;
        div_start     = 1'b0;
        div_dividend  = num_mag[DIV_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    e_next     = sample.error_sample;
                    dt_next    = sample.time_step;
                    sum_next   = '0;
                    state_next = S_P_GO;
                end
            end
            S_P_GO:
            begin
                if (kp_reg != '0)
                begin
                    mac_start  = 1'b1;
                    state_next = S_P_WAIT;
                end
                else
                begin
                    state_next = S_I_GO;
                end
            end
            S_P_WAIT:
            begin
                if (mac_done)
                begin
                    sum_next   = sum_reg + rnd_term;
                    state_next = S_I_GO;
                end
            end
            S_I_GO:
            begin
                // error times time step first, then integral times gain
                mac_b = $signed(MAC_B_W'(dt_reg));
                if (ki_reg != '0)
                begin
                    mac_start  = 1'b1;
                    state_next = S_INC_WAIT;
                end
                else
                begin
                    state_next = S_D_GO;
                end
            end
            S_INC_WAIT:
            begin
                if (mac_done)
                begin
                    integral_next = integ_sat;
                    state_next    = S_IACC_GO;
                end
            end
            S_IACC_GO:
            begin
                mac_a      = integral_reg;
                mac_b      = ki_reg;
                mac_start  = 1'b1;
                state_next = S_I_WAIT;
            end
            S_I_WAIT:
            begin
                if (mac_done)
                begin
                    sum_next   = sum_reg + rnd_term;
                    state_next = S_D_GO;
                end
            end
            S_D_GO:
            begin
                mac_a = MAC_A_W'(diff);
                mac_b = kd_reg;
                if (kd_reg != '0)
                begin
                    mac_start  = 1'b1;
                    state_next = S_D_WAIT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_D_WAIT:
            begin
                if (mac_done)
                begin
                    prev_next = e_reg;
                    // zero time step drops the derivative term
                    if (dt_reg != '0)
                    begin
                        neg_next   = mac_prod[PROD_W-1];
                        div_start  = 1'b1;
                        state_next = S_DIV_WAIT;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    sum_next   = sum_reg + $signed(d_term) + SUM_W'(neg_reg);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        drive_next     = drive_reg;
        clamped_next   = clamped_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_valid_next = 1'b1;
            clamped_next   = over || under;
            if (over)
            begin
                drive_next = lim_pos[ERR_W-1:0];
            end
            else if (under)
            begin
                drive_next = lim_neg_reg;
            end
            else
            begin
                drive_next = sum_reg[ERR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            integral_reg  <= integral_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg       <= e_next;
        dt_reg      <= dt_next;
        sum_reg     <= sum_next;
        neg_reg     <= neg_next;
        drive_reg   <= drive_next;
        clamped_reg <= clamped_next;
    end

    assign sample.ready   = (state_reg == S_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.drive   = drive_reg;
    assign result.clamped = clamped_reg;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// testbench for pid_controller_step_core: a directed table, randomized register settings
// under four idling mixes, and an integrator run to its upper bound, checked by a predictor
// depends on pidstep_pkg, the pidstep channel interfaces and the core with its serial units
`timescale 1ns / 100ps

module testbench;
    import pidstep_pkg::*;

    // register indexes outside the map, writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_CYCLES     = 300;   // long result hold-off, fills the core
    localparam int TAIL_CYCLES     = 100;   // idle tail after the last result
    localparam int N_DIRECTED      = 44;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

    // one directed row: a register write, or a sample with an optional typed result
    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;     // write data, or the error sample
        dt_t                   dt;
        logic                  typed;
        err_t                  drive;
        logic                  clamped;
    } row_t;

    typedef struct {
        err_t drive;
        logic clamped;
    } drive_expect_t;

    logic clk = 1'b0;
    logic rst_n;

    pidstep_cfg_if cfg_bus ();
    pidstep_in_if  sample_bus ();
    pidstep_out_if result_bus ();

    pid_controller_step_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus.sink),
        .sample (sample_bus.sink),
        .result (result_bus.source)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor copy of the registers and of the controller state
    gain_t                     kp_q       = '0;
    gain_t                     ki_q       = '0;
    gain_t                     kd_q       = '0;
    limit_t                    limit_q    = '1;
    logic signed [INTEG_W-1:0] integ_q    = '0;
    err_t                      last_err_q = '0;

    drive_expect_t pending_drives[$];

    idle_mode_e idle_mode     = IDLE_NONE;
    int         hold_requests = 0;   // bumped by the stimulus side
    int         hold_served   = 0;   // bumped by the result side
    int         error_count   = 0;
    int         samples_sent  = 0;
    int         writes_done   = 0;
    int         results_checked = 0;
    int         settings_count  = 0;

    // directed rows; results typed only where they follow from the gains at a glance
    row_t directed_rows [N_DIRECTED] = '{
        // gains at reset are zero, every sample gives zero
        '{ROW_SAMPLE, 8'd0, 32'h7FFFFFFF, 16'h0001, 1'b1, 32'h00000000, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h80000000, 16'hFFFF, 1'b1, 32'h00000000, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h00000000, 16'h0000, 1'b1, 32'h00000000, 1'b0},
        // unit proportional gain passes the error through
        '{ROW_WRITE,  REG_GAIN_PROP, 32'h00010000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h00050000, 16'h0100, 1'b1, 32'h00050000, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h7FFFFFFF, 16'h0001, 1'b1, 32'h7FFFFFFF, 1'b0},
        // most negative error falls outside the symmetric full scale limit
        '{ROW_SAMPLE, 8'd0, 32'h80000000, 16'h0001, 1'b1, 32'h80000001, 1'b1},
        // largest gain saturates
        '{ROW_WRITE,  REG_GAIN_PROP, 32'h007FFFFF, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h7FFFFFFF, 16'h0001, 1'b1, 32'h7FFFFFFF, 1'b1},
        // most negative gain, with junk in the high byte of the write
        '{ROW_WRITE,  REG_GAIN_PROP, 32'hFF800000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h7FFFFFFF, 16'h0001, 1'b1, 32'h80000001, 1'b1},
        '{ROW_SAMPLE, 8'd0, 32'hFFFF0000, 16'h0001, 1'b1, 32'h00800000, 1'b0},
        // limit of 1.0, bit 31 of the write must be dropped
        '{ROW_WRITE,  REG_OUTPUT_LIMIT, 32'h80010000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'hFFFF0000, 16'h0001, 1'b1, 32'h00010000, 1'b1},
        '{ROW_SAMPLE, 8'd0, 32'h00010000, 16'h0001, 1'b1, 32'hFFFF0000, 1'b1},
        // zero limit: zero drive, flag set only for a nonzero sum
        '{ROW_WRITE,  REG_OUTPUT_LIMIT, 32'h00000000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h00000001, 16'h0001, 1'b1, 32'h00000000, 1'b1},
        '{ROW_SAMPLE, 8'd0, 32'h00000000, 16'h0001, 1'b1, 32'h00000000, 1'b0},
        // writes past the register map change nothing
        '{ROW_WRITE,  REG_UNUSED_LOW,  32'h00000000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_UNUSED_HIGH, 32'hFFFFFFFF, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h00000001, 16'h0001, 1'b1, 32'h00000000, 1'b1},
        // integral only: half a second of 1.0 gives 0.5
        '{ROW_WRITE,  REG_OUTPUT_LIMIT,  32'h7FFFFFFF, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_PROP,     32'h00000000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_INTEGRAL, 32'h00010000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h00010000, 16'h8000, 1'b1, 32'h00008000, 1'b0},
        // zero time step adds nothing to the integrator
        '{ROW_SAMPLE, 8'd0, 32'h00010000, 16'h0000, 1'b1, 32'h00008000, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h80000000, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_INTEGRAL, 32'h00800000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h7FFFFFFF, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        // derivative only
        '{ROW_WRITE,  REG_GAIN_INTEGRAL, 32'h00000000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_DERIV,    32'h00010000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h00020000, 16'h1000, 1'b0, 32'h0, 1'b0},
        // zero time step: no derivative, but the previous error still moves
        '{ROW_SAMPLE, 8'd0, 32'h00030000, 16'h0000, 1'b1, 32'h00000000, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h00030000, 16'h0001, 1'b1, 32'h00000000, 1'b0},
        '{ROW_WRITE,  REG_GAIN_DERIV,    32'h007FFFFF, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h80000000, 16'h0001, 1'b1, 32'h80000001, 1'b1},
        '{ROW_SAMPLE, 8'd0, 32'h7FFFFFFF, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_DERIV,    32'h00800000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h80000000, 16'h0001, 1'b1, 32'h7FFFFFFF, 1'b1},
        // all three terms together
        '{ROW_WRITE,  REG_GAIN_PROP,     32'h00018000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_INTEGRAL, 32'h0000C000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_DERIV,    32'h00004000, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'h00012345, 16'h0400, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, 8'd0, 32'hFFFE8000, 16'h0C00, 1'b0, 32'h0, 1'b0}
    };

    // q16 rounding: add half, floor shift
    function automatic longint round_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    // one controller step on the predictor state
    function automatic void pid_predict(input err_t e, input dt_t dt,
                                        output err_t drive, output logic clamped);
        longint total;
        longint acc;
        longint hi;
        longint lo;
        total   = 0;
        clamped = 1'b0;
        if (kp_q != 0)
            total += round_q16(longint'(kp_q) * longint'(e));
        // integrator moves before it is used, only with a live integral gain
        if (ki_q != 0)
        begin
            acc = longint'(integ_q) + round_q16(longint'(e) * longint'(dt));
            if (acc > longint'(INTEG_MAX))
                acc = longint'(INTEG_MAX);
            if (acc < longint'(INTEG_MIN))
                acc = longint'(INTEG_MIN);
            integ_q = acc[INTEG_W-1:0];
            // split so the product is exact: whole part times gain, fraction rounded
            hi = acc >>> 16;
            lo = acc - hi * 65536;
            total += longint'(ki_q) * hi + round_q16(longint'(ki_q) * lo);
        end
        // derivative quotient truncates toward zero, zero step gives no term
        if (kd_q != 0)
        begin
            if (dt != 0)
                total += (longint'(kd_q) * (longint'(e) - longint'(last_err_q)))
                         / longint'(dt);
            last_err_q = e;
        end
        if (total > 64'sd2147483647)
        begin
            total   = 64'sd2147483647;
            clamped = 1'b1;
        end
        if (total < -64'sd2147483648)
        begin
            total   = -64'sd2147483648;
            clamped = 1'b1;
        end
        if (total > longint'(limit_q))
        begin
            total   = longint'(limit_q);
            clamped = 1'b1;
        end
        if (total < -longint'(limit_q))
        begin
            total   = -longint'(limit_q);
            clamped = 1'b1;
        end
        drive = total[ERR_W-1:0];
    endfunction

    // random gain word, high byte left random since the core must ignore it
    function automatic logic [CFG_DATA_W-1:0] pick_gain_word();
        logic [CFG_DATA_W-1:0] w;
        w = $urandom();
        case ($urandom_range(0, 5))
            0: w[GAIN_W-1:0] = '0;
            1: w[GAIN_W-1:0] = 24'h7FFFFF;
            2: w[GAIN_W-1:0] = 24'h800000;
            3, 4: w[GAIN_W-1:0] = $urandom_range(0, 32'h0007FFFF) - 32'h00040000;
            default: ;
        endcase
        return w;
    endfunction

    // register write request; valid stays up so back-to-back writes never glitch it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        writes_done++;
        case (idx)
            REG_GAIN_PROP:     kp_q    = data[GAIN_W-1:0];
            REG_GAIN_INTEGRAL: ki_q    = data[GAIN_W-1:0];
            REG_GAIN_DERIV:    kd_q    = data[GAIN_W-1:0];
            REG_OUTPUT_LIMIT:  limit_q = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // sample request with a random lead-in gap under the sender idling mixes; the result is predicted on acceptance
    task automatic send_sample(input err_t e, input dt_t dt, input logic typed = 1'b0,
                               input err_t typed_drive = '0,
                               input logic typed_clamped = 1'b0);
        drive_expect_t want;
        cfg_bus.valid <= 1'b0;
        while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 62) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 10))
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid        <= 1'b1;
        sample_bus.error_sample <= e;
        sample_bus.time_step    <= dt;
        do @(posedge clk); while (!sample_bus.ready);
        pid_predict(e, dt, want.drive, want.clamped);
        if (typed)
        begin
            want.drive   = typed_drive;
            want.clamped = typed_clamped;
        end
        pending_drives.push_back(want);
        samples_sent++;
    endtask

    // stop offering samples and wait until every result is back, core is then idle
    task automatic park_and_drain();
        sample_bus.valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] word;
        err_t                  e;
        dt_t                   dt;

        rst_n                   <= 1'b0;
        sample_bus.valid        <= 1'b0;
        sample_bus.error_sample <= '0;
        sample_bus.time_step    <= '0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.index           <= '0;
        cfg_bus.data            <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset settings count as the first
        settings_count = 1;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                park_and_drain();
                write_reg(directed_rows[i].index, directed_rows[i].value);
                settings_count++;
            end
            else
                send_sample(directed_rows[i].value, directed_rows[i].dt,
                            directed_rows[i].typed, directed_rows[i].drive,
                            directed_rows[i].clamped);
        end

        // random phases: fresh settings each, idling mix cycles through all four
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            park_and_drain();
            idle_mode = idle_mode_e'(phase % 4);
            if (phase == 1)
            begin
                // largest gains, full scale limit
                write_reg(REG_GAIN_PROP, 32'h007FFFFF);
                write_reg(REG_GAIN_INTEGRAL, 32'h007FFFFF);
                write_reg(REG_GAIN_DERIV, 32'h007FFFFF);
                write_reg(REG_OUTPUT_LIMIT, 32'h7FFFFFFF);
            end
            else if (phase == 2)
            begin
                // most negative gains, smallest nonzero limit
                write_reg(REG_GAIN_PROP, 32'h00800000);
                write_reg(REG_GAIN_INTEGRAL, 32'h00800000);
                write_reg(REG_GAIN_DERIV, 32'h00800000);
                write_reg(REG_OUTPUT_LIMIT, 32'h00000001);
            end
            else
            begin
                write_reg(REG_GAIN_PROP, pick_gain_word());
                write_reg(REG_GAIN_INTEGRAL, pick_gain_word());
                write_reg(REG_GAIN_DERIV, pick_gain_word());
                case ($urandom_range(0, 3))
                    0: word = 32'h7FFFFFFF;
                    1: word = $urandom_range(0, 32'h00FF0000);
                    2: word = $urandom();
                    default: word = '0;
                endcase
                write_reg(REG_OUTPUT_LIMIT, word);
            end
            settings_count++;
            // first phase has no idling; the long result hold-off lands here
            if (phase == 0)
                hold_requests++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // half the errors are small so terms stay in range, the rest random or full scale
                case ($urandom_range(0, 7))
                    0: e = 32'h7FFFFFFF;
                    1: e = 32'h80000000;
                    2, 3: e = $urandom();
                    default: e = $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
                endcase
                case ($urandom_range(0, 7))
                    0: dt = '0;
                    1: dt = $urandom_range(1, 16);
                    default: dt = $urandom_range(1, 16'hFFFF);
                endcase
                send_sample(e, dt);
            end
        end

        // integrator run: smallest integral gain makes the drive track the
        // integrator, so the upper bound and the step back from it are visible
        park_and_drain();
        idle_mode = IDLE_NONE;
        write_reg(REG_GAIN_PROP, '0);
        write_reg(REG_GAIN_DERIV, '0);
        write_reg(REG_GAIN_INTEGRAL, 32'h00000001);
        write_reg(REG_OUTPUT_LIMIT, 32'h7FFFFFFF);
        settings_count++;
        while (integ_q != INTEG_MAX)
            send_sample(32'h7FFFFFFF, 16'hFFFF);
        // pinned at the bound, then back off by whole increments
        repeat (4) send_sample(32'h7FFFFFFF, 16'hFFFF);
        repeat (4) send_sample(32'h80000000, 16'hFFFF);

        park_and_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d sample requests and %0d register writes over %0d settings, %0d results checked",
                 samples_sent, writes_done, settings_count, results_checked);
        $display("all four idling mixes, a %0d-cycle result hold-off, integrator run to its bound",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: checks each accepted result, then decides ready for the next edge
    initial
    begin : result_sink
        drive_expect_t want;
        int            hold_left;

        hold_left         = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                if (pending_drives.size() == 0)
                begin
                    $error("result with no sample pending: drive %h clamped %b",
                           result_bus.drive, result_bus.clamped);
                    error_count++;
                end
                else
                begin
                    want = pending_drives.pop_front();
                    results_checked++;
                    if (result_bus.drive !== want.drive)
                    begin
                        $error("drive mismatch: expected %h, actual %h",
                               want.drive, result_bus.drive);
                        error_count++;
                    end
                    if (result_bus.clamped !== want.clamped)
                    begin
                        $error("clamped mismatch: expected %b, actual %b",
                               want.clamped, result_bus.clamped);
                        error_count++;
                    end
                end
            end
            // a requested hold-off is counted here while the sender keeps offering
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left         = HOLD_CYCLES;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 62) ||
                                      (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 10));
        end
    end

    // slowest correct run is about 30 ms, mostly the integrator run
    initial
    begin : watchdog
        #400ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
